// ===== src/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the running median queue: field widths,
// operation codes, the chain command and the link between neighboring cells.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 11;
   localparam int HEAP_DEPTH_DEF = 512;

   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      CH_NOP,
      CH_INSERT,
      CH_POP,
      CH_EXCHANGE
   } chain_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SEND
   } state_type;

   typedef struct packed {
      chain_op_type               op;
      logic signed [VALUE_W-1:0]  value;
   } chain_cmd_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  value;
      logic                       above;
   } cell_link_type;

   localparam cell_link_type LINK_HEAD = '{value: '0, above: 1'b1};
   localparam cell_link_type LINK_TAIL = '{value: '0, above: 1'b0};

endpackage

// ===== src/running_median_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_queue
// Median priority queue: a lower max-chain and an upper min-chain of sorted
// cells, kept within one entry of each other in size.
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    req_op, req_value
//   rsp       out   rsp_valid/rsp_ready    rsp_removed_value, rsp_underflow,
//                                          rsp_overflow, rsp_median_value,
//                                          rsp_median_valid, rsp_count
//
// One item at a time: the accept beat in ST_IDLE, then ST_EVAL, in which the
// chains have settled and the median is registered, then the result beat in
// ST_SEND. Every chain operation updates all cells at the same clock edge.
// Reset clears the sizes and the control state only; cell contents are
// don't-care until written. A held result stalls the input side.
// ----------------------------------------------------------------------------
module running_median_queue
   import rmq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic signed [VALUE_W-1:0]   req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [VALUE_W-1:0]   rsp_removed_value,
   output logic                        rsp_underflow,
   output logic                        rsp_overflow,
   output logic signed [VALUE_W-1:0]   rsp_median_value,
   output logic                        rsp_median_valid,
   output logic [COUNT_W-1:0]          rsp_count
);

   localparam int SIZE_W = $clog2(HEAP_DEPTH + 1);
   localparam int CNT_W  = SIZE_W + 1;

   state_type                 state_ff, state_in;
   logic [SIZE_W-1:0]         lower_size_ff, lower_size_in;
   logic [SIZE_W-1:0]         upper_size_ff, upper_size_in;
   logic signed [VALUE_W-1:0] removed_ff, removed_in;
   logic                      underflow_ff, underflow_in;
   logic                      overflow_ff, overflow_in;
   logic signed [VALUE_W-1:0] median_ff, median_in;
   logic                      median_valid_ff, median_valid_in;
   logic [COUNT_W-1:0]        count_ff, count_in;

   chain_cmd_type             lower_cmd, upper_cmd;
   logic signed [VALUE_W-1:0] lower_top, upper_top;
   logic [CNT_W-1:0]          lower_ext, upper_ext, total;
   logic                      accept, eval, full, go_lower;

   rmq_chain #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .IS_MAX     (1'b1)
   ) u_lower (
      .clock      (clock),
      .cmd        (lower_cmd),
      .size       (lower_size_ff),
      .top_value  (lower_top)
   );

   rmq_chain #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .IS_MAX     (1'b0)
   ) u_upper (
      .clock      (clock),
      .cmd        (upper_cmd),
      .size       (upper_size_ff),
      .top_value  (upper_top)
   );

   assign lower_ext = CNT_W'(lower_size_ff);
   assign upper_ext = CNT_W'(upper_size_ff);
   assign total     = lower_ext + upper_ext;
   assign full      = total == CNT_W'(2 * HEAP_DEPTH);
   assign go_lower  = (total == '0) || ((lower_size_ff != '0) && (req_value <= lower_top));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      eval      = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = !reset;
         ST_EVAL: eval      = 1'b1;
         ST_SEND: rsp_valid = 1'b1;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   // beat decode and chain commands
   always_comb begin
      lower_cmd     = '{op: CH_NOP, value: req_value};
      upper_cmd     = '{op: CH_NOP, value: req_value};
      lower_size_in = lower_size_ff;
      upper_size_in = upper_size_ff;
      removed_in    = removed_ff;
      underflow_in  = underflow_ff;
      overflow_in   = overflow_ff;
      if (accept) begin
         removed_in   = '0;
         underflow_in = 1'b0;
         overflow_in  = 1'b0;
         if (req_op == OP_PUSH) begin
            if (full) begin
               overflow_in = 1'b1;
            end else if (go_lower) begin
               if (lower_ext == upper_ext + CNT_W'(1)) begin
                  if (lower_top > req_value) begin
                     lower_cmd = '{op: CH_EXCHANGE, value: req_value};
                     upper_cmd = '{op: CH_INSERT, value: lower_top};
                  end else begin
                     upper_cmd = '{op: CH_INSERT, value: req_value};
                  end
                  upper_size_in = upper_size_ff + SIZE_W'(1);
               end else begin
                  lower_cmd     = '{op: CH_INSERT, value: req_value};
                  lower_size_in = lower_size_ff + SIZE_W'(1);
               end
            end else begin
               if (upper_ext == lower_ext + CNT_W'(1)) begin
                  if (upper_top < req_value) begin
                     upper_cmd = '{op: CH_EXCHANGE, value: req_value};
                     lower_cmd = '{op: CH_INSERT, value: upper_top};
                  end else begin
                     lower_cmd = '{op: CH_INSERT, value: req_value};
                  end
                  lower_size_in = lower_size_ff + SIZE_W'(1);
               end else begin
                  upper_cmd     = '{op: CH_INSERT, value: req_value};
                  upper_size_in = upper_size_ff + SIZE_W'(1);
               end
            end
         end else begin
            if (total == '0) begin
               underflow_in = 1'b1;
            end else if (lower_size_ff >= upper_size_ff) begin
               lower_cmd     = '{op: CH_POP, value: req_value};
               removed_in    = lower_top;
               lower_size_in = lower_size_ff - SIZE_W'(1);
            end else begin
               upper_cmd     = '{op: CH_POP, value: req_value};
               removed_in    = upper_top;
               upper_size_in = upper_size_ff - SIZE_W'(1);
            end
         end
      end
   end

   // median and count once the chains have settled
   always_comb begin
      median_in       = median_ff;
      median_valid_in = median_valid_ff;
      count_in        = count_ff;
      if (eval) begin
         median_valid_in = total != '0;
         count_in        = COUNT_W'(total);
         if (total == '0) begin
            median_in = '0;
         end else if (lower_size_ff >= upper_size_ff) begin
            median_in = lower_top;
         end else begin
            median_in = upper_top;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lower_size_ff <= '0;
         upper_size_ff <= '0;
      end else begin
         state_ff      <= state_in;
         lower_size_ff <= lower_size_in;
         upper_size_ff <= upper_size_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff      <= removed_in;
      underflow_ff    <= underflow_in;
      overflow_ff     <= overflow_in;
      median_ff       <= median_in;
      median_valid_ff <= median_valid_in;
      count_ff        <= count_in;
   end

   assign rsp_removed_value = removed_ff;
   assign rsp_underflow     = underflow_ff;
   assign rsp_overflow      = overflow_ff;
   assign rsp_median_value  = median_ff;
   assign rsp_median_valid  = median_valid_ff;
   assign rsp_count         = count_ff;

endmodule

// ===== src/rmq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_cell
// One slot of a sorted chain. Holds one value, flags whether it ranks above
// the command value, and takes its next value from itself, a neighbor or the
// command.
// ----------------------------------------------------------------------------
module rmq_cell
   import rmq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
   parameter int INDEX      = 0,
   parameter bit IS_MAX     = 1'b1
) (
   input  logic                               clock,
   input  chain_cmd_type                      cmd,
   input  logic [$clog2(HEAP_DEPTH+1)-1:0]    size,
   input  cell_link_type                      from_prev,
   input  cell_link_type                      from_next,
   output cell_link_type                      link
);

   localparam int SIZE_W = $clog2(HEAP_DEPTH + 1);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      occupied;
   logic                      above;

   assign occupied = size > SIZE_W'(INDEX);
   assign above    = occupied && (IS_MAX ? (value_ff > cmd.value) : (value_ff < cmd.value));

   assign link = '{value: value_ff, above: above};

   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         CH_INSERT: begin
            if (above) begin
               value_in = value_ff;
            end else if (from_prev.above) begin
               value_in = cmd.value;
            end else begin
               value_in = from_prev.value;
            end
         end
         CH_POP: begin
            value_in = from_next.value;
         end
         CH_EXCHANGE: begin
            if (from_next.above) begin
               value_in = from_next.value;
            end else if (above) begin
               value_in = cmd.value;
            end else begin
               value_in = value_ff;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== src/rmq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_chain
// Sorted row of cells acting as one heap. The top (max or min) sits in the
// first cell; insert, pop and exchange update all cells at the same edge.
// ----------------------------------------------------------------------------
module rmq_chain
   import rmq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
   parameter bit IS_MAX     = 1'b1
) (
   input  logic                               clock,
   input  chain_cmd_type                      cmd,
   input  logic [$clog2(HEAP_DEPTH+1)-1:0]    size,
   output logic signed [VALUE_W-1:0]          top_value
);

   cell_link_type links [HEAP_DEPTH];

   assign top_value = links[0].value;

   for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
      cell_link_type prev_link;
      cell_link_type next_link;

      if (i == 0) begin : g_head
         assign prev_link = LINK_HEAD;
      end else begin : g_body
         assign prev_link = links[i-1];
      end

      if (i == HEAP_DEPTH - 1) begin : g_tail
         assign next_link = LINK_TAIL;
      end else begin : g_mid
         assign next_link = links[i+1];
      end

      rmq_cell #(
         .HEAP_DEPTH (HEAP_DEPTH),
         .INDEX      (i),
         .IS_MAX     (IS_MAX)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .size       (size),
         .from_prev  (prev_link),
         .from_next  (next_link),
         .link       (links[i])
      );
   end

endmodule

// ===== verif/rmq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker
// Watches the request and result channels of the running median queue. Each
// accepted request beat updates a sorted image of the held values, split into
// a lower and an upper part of tracked sizes. The expected result is queued
// and then compared field by field with the next result beat.
// ----------------------------------------------------------------------------
module rmq_checker
   import rmq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_op,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [VALUE_W-1:0]   rsp_removed_value,
   input  logic                        rsp_underflow,
   input  logic                        rsp_overflow,
   input  logic signed [VALUE_W-1:0]   rsp_median_value,
   input  logic                        rsp_median_valid,
   input  logic [COUNT_W-1:0]          rsp_count,
   output int                          fail_count,
   output int                          pending,
   output int                          results_seen,
   output int                          underflows_seen,
   output int                          overflows_seen,
   output int                          peak_fill
);

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed;
      logic                      underflow;
      logic                      overflow;
      logic signed [VALUE_W-1:0] median;
      logic                      median_valid;
      logic [COUNT_W-1:0]        held_count;
   } median_result_type;

   // ascending; the first lower_n entries form the lower half
   logic signed [VALUE_W-1:0] held_values[$];
   int                        lower_n;
   int                        upper_n;
   median_result_type         median_results_due[$];

   task automatic report_mismatch(input string what);
      $display("rmq_checker: %s", what);
      fail_count++;
   endtask

   function automatic median_result_type next_median_result(input logic op,
                                                            input logic signed [VALUE_W-1:0] v);
      median_result_type r;
      int                total;
      int                at;
      r = '0;
      total = lower_n + upper_n;
      if (op == OP_PUSH) begin
         if (total >= 2 * HEAP_DEPTH) begin
            r.overflow = 1'b1;
         end else begin
            if (total == 0 || (lower_n > 0 && v <= held_values[lower_n-1])) begin
               if (lower_n == upper_n + 1) upper_n++;
               else lower_n++;
            end else begin
               if (upper_n == lower_n + 1) lower_n++;
               else upper_n++;
            end
            at = 0;
            while (at < held_values.size() && held_values[at] <= v) at++;
            held_values.insert(at, v);
         end
      end else if (total == 0) begin
         r.underflow = 1'b1;
      end else if (lower_n >= upper_n) begin
         r.removed = held_values[lower_n-1];
         held_values.delete(lower_n-1);
         lower_n--;
      end else begin
         r.removed = held_values[lower_n];
         held_values.delete(lower_n);
         upper_n--;
      end
      total = lower_n + upper_n;
      r.held_count   = total[COUNT_W-1:0];
      r.median_valid = (total != 0);
      if (total != 0)
         r.median = (lower_n >= upper_n) ? held_values[lower_n-1] : held_values[lower_n];
      return r;
   endfunction

   always @(posedge clock) begin
      median_result_type want;
      median_result_type got;
      if (reset) begin
         held_values.delete();
         median_results_due.delete();
         lower_n         = 0;
         upper_n         = 0;
         fail_count      = 0;
         pending         = 0;
         results_seen    = 0;
         underflows_seen = 0;
         overflows_seen  = 0;
         peak_fill       = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{removed: rsp_removed_value, underflow: rsp_underflow,
                    overflow: rsp_overflow, median: rsp_median_value,
                    median_valid: rsp_median_valid, held_count: rsp_count};
            if (median_results_due.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with no request pending",
                                         results_seen));
            end else begin
               want = median_results_due.pop_front();
               if (got.removed !== want.removed)
                  report_mismatch($sformatf("beat %0d removed_value %0d, expected %0d",
                                            results_seen, got.removed, want.removed));
               if (got.underflow !== want.underflow)
                  report_mismatch($sformatf("beat %0d underflow %b, expected %b",
                                            results_seen, got.underflow, want.underflow));
               if (got.overflow !== want.overflow)
                  report_mismatch($sformatf("beat %0d overflow %b, expected %b",
                                            results_seen, got.overflow, want.overflow));
               if (got.median !== want.median)
                  report_mismatch($sformatf("beat %0d median_value %0d, expected %0d",
                                            results_seen, got.median, want.median));
               if (got.median_valid !== want.median_valid)
                  report_mismatch($sformatf("beat %0d median_valid %b, expected %b",
                                            results_seen, got.median_valid,
                                            want.median_valid));
               if (got.held_count !== want.held_count)
                  report_mismatch($sformatf("beat %0d count %0d, expected %0d",
                                            results_seen, got.held_count, want.held_count));
               if (want.underflow) underflows_seen++;
               if (want.overflow) overflows_seen++;
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            median_results_due.push_back(next_median_result(req_op, req_value));
            if (lower_n + upper_n > peak_fill) peak_fill = lower_n + upper_n;
         end
         pending = median_results_due.size();
      end
   end

endmodule

// ===== verif/tb_running_median_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_median_queue
// Regression of the running median queue. A directed opening walks through
// the value extremes, ties, removes from either half and removes on an empty
// store. Random traffic follows: small mixed fills, one fill to capacity with
// rejected pushes, and a drain. Both sides idle at random; the result side
// also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_running_median_queue
   import rmq_pkg::*;
();

   localparam int DEPTH        = HEAP_DEPTH_DEF;
   localparam int CAPACITY     = 2 * DEPTH;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_op;
   logic signed [VALUE_W-1:0]   req_value;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [VALUE_W-1:0]   rsp_removed_value;
   logic                        rsp_underflow;
   logic                        rsp_overflow;
   logic signed [VALUE_W-1:0]   rsp_median_value;
   logic                        rsp_median_valid;
   logic [COUNT_W-1:0]          rsp_count;

   int fail_count;
   int pending;
   int results_seen;
   int underflows_seen;
   int overflows_seen;
   int peak_fill;

   int level;
   bit quiet;
   bit hold_request;

   running_median_queue #(.HEAP_DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_removed_value (rsp_removed_value),
      .rsp_underflow     (rsp_underflow),
      .rsp_overflow      (rsp_overflow),
      .rsp_median_value  (rsp_median_value),
      .rsp_median_valid  (rsp_median_valid),
      .rsp_count         (rsp_count)
   );

   rmq_checker #(.HEAP_DEPTH(DEPTH)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_removed_value (rsp_removed_value),
      .rsp_underflow     (rsp_underflow),
      .rsp_overflow      (rsp_overflow),
      .rsp_median_value  (rsp_median_value),
      .rsp_median_valid  (rsp_median_valid),
      .rsp_count         (rsp_count),
      .fail_count        (fail_count),
      .pending           (pending),
      .results_seen      (results_seen),
      .underflows_seen   (underflows_seen),
      .overflows_seen    (overflows_seen),
      .peak_fill         (peak_fill)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [VALUE_W-1:0] rand_value();
      case ($urandom_range(9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return $urandom_range(1) ? '0 : '1;
         3, 4, 5: return $signed($urandom_range(16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // one request beat; leaves valid high after acceptance
   task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] v);
      while (!quiet && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_PUSH) begin
         if (level < CAPACITY) level++;
      end else if (level > 0) begin
         level--;
      end
   endtask

   task automatic send_mixed(input int n, input int remove_pct);
      for (int i = 0; i < n; i++)
         send_item(($urandom_range(99) < remove_pct) ? OP_REMOVE : OP_PUSH, rand_value());
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   // result side: random idling, one long hold-off on request
   initial begin
      int hold_count;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready  <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 35);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
      $display("running_median_queue regression: fail");
      $finish;
   end

   initial begin
      level        = 0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_op    <= OP_PUSH;
      req_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty remove, ties, extremes, removes from both halves
      send_item(OP_REMOVE, VAL_MAX);
      send_item(OP_PUSH, '0);
      send_item(OP_PUSH, '0);
      send_item(OP_PUSH, VAL_MAX);
      send_item(OP_PUSH, VAL_MIN);
      send_item(OP_PUSH, '1);
      send_item(OP_PUSH, VAL_MAX);
      send_item(OP_PUSH, VAL_MIN);
      repeat (8) send_item(OP_REMOVE, VAL_MIN);
      send_item(OP_PUSH, 5);
      send_item(OP_PUSH, 9);
      send_item(OP_REMOVE, '0);
      send_item(OP_PUSH, 7);
      send_item(OP_PUSH, 1);
      repeat (4) send_item(OP_REMOVE, '1);
      drain_requests();

      // small mixed traffic with a long result hold-off, then a quiet stretch
      send_mixed(12, 45);
      hold_request = 1'b1;
      send_mixed(12, 45);
      quiet = 1'b1;
      send_mixed(12, 45);
      quiet = 1'b0;
      drain_requests();

      // fill to capacity, mostly pushes
      while (level < CAPACITY) begin
         quiet = (level >= 200 && level < 500);
         send_item(($urandom_range(99) < 1) ? OP_REMOVE : OP_PUSH, rand_value());
      end
      quiet = 1'b0;
      repeat (4) send_item(OP_PUSH, rand_value());
      send_mixed(10, 40);
      while (level < CAPACITY) send_item(OP_PUSH, rand_value());
      send_item(OP_PUSH, rand_value());

      // drain side, removes dominate
      send_mixed(24, 70);
      drain_requests();
      repeat (20) @(posedge clock);

      $display("covered %0d results: %0d underflows, %0d overflows, peak fill %0d of %0d",
               results_seen, underflows_seen, overflows_seen, peak_fill, CAPACITY);
      $display("traffic: directed corners, small mixed fills, one long result hold-off, %s",
               "a fill to capacity and a partial drain");
      if (fail_count == 0 && pending == 0) begin
         $display("running_median_queue regression: pass");
      end else begin
         $display("running_median_queue regression: fail");
      end
      $finish;
   end

endmodule

// ===== running_median_queue.f =====
src/rmq_pkg.sv
src/rmq_cell.sv
src/rmq_chain.sv
src/running_median_queue.sv
verif/rmq_checker.sv
verif/tb_running_median_queue.sv
